[src/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/irclt_pkg.sv]
// Shared types, codes and helpers for the IRC line tokenizer.
// No dependencies; imported by every tokenizer module.
package irclt_pkg;

  localparam int MAX_LINE_DEF = 512;
  localparam int QDEPTH       = 4;
  localparam int RECS_PER_BND = 3;

  // token kinds
  localparam logic [2:0] KIND_PREFIX = 3'd0;
  localparam logic [2:0] KIND_CMD    = 3'd1;
  localparam logic [2:0] KIND_MIDDLE = 3'd2;
  localparam logic [2:0] KIND_REST   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;

  // "PASS" matcher codes
  localparam logic [2:0] PM_MATCHED = 3'd4;
  localparam logic [2:0] PM_HIT_WS  = 3'd5;
  localparam logic [2:0] PM_MISS    = 3'd6;

  typedef struct packed {
    logic [2:0] kind;
    logic [8:0] start;
    logic [9:0] stop;
    logic [7:0] index;
    logic       ovf;
    logic       last;
  } rec_t;

  // up to three records caused by one byte, in emission order
  typedef struct packed {
    logic [1:0]                   cnt;
    rec_t [RECS_PER_BND-1:0]      recs;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [7:0] pass_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_P;
      2'd1:    c = CH_A;
      default: c = CH_S;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pass_feed(input logic [2:0] pm, input logic [7:0] b,
                                           input logic ws);
    logic [7:0] u;
    logic [2:0] r;
    u = (b >= CH_LA && b <= CH_LZ) ? b - CH_CASE : b;
    if (pm >= PM_MISS)
      r = pm;
    else if (ws)
      r = (pm >= PM_MATCHED) ? PM_HIT_WS : PM_MISS;
    else if (pm < PM_MATCHED && u == pass_char(pm[1:0]))
      r = pm + 3'd1;
    else
      r = PM_MISS;
    return r;
  endfunction

endpackage

[src/irclt_front.sv]
// Front end of the IRC line tokenizer: byte classification and token state.
// Depends on irclt_pkg and assert_macros.svh; feeds irclt_queue.
`include "assert_macros.svh"
module irclt_front
  import irclt_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_line_byte,
  input  logic       in_line_end,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_bnd
);

  localparam int OFFW = $clog2(MAX_LINE + 1);
  localparam logic [OFFW-1:0] OFF_MAX  = OFFW'(MAX_LINE);
  localparam logic [OFFW-1:0] OFF_LAST = OFFW'(MAX_LINE - 1);
  localparam logic [OFFW-1:0] OFF_ONE  = OFFW'(1);

  typedef enum logic [2:0] {
    PH_LINE_START, PH_PREFIX, PH_TOK_START, PH_SEGMENT, PH_REST, PH_AFTER_PASS
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [OFFW-1:0] off_r, off_nxt;
  logic [OFFW-1:0] tbeg_r, tbeg_nxt;
  logic [OFFW-1:0] lke_r, lke_nxt;
  logic [7:0]      tseen_r, tseen_nxt;
  logic [2:0]      pm_r, pm_nxt;
  logic            ovf_r, ovf_nxt;

  logic            acc;
  logic            seg_go, is_cmd, is_pass;
  logic [7:0]      idx;
  logic [1:0]      cnt;
  bundle_t         bnd;

  function automatic rec_t mk_rec(input logic [2:0] kind, input logic [OFFW-1:0] st,
                                  input logic [OFFW-1:0] sp, input logic [7:0] ix,
                                  input logic ov, input logic lst);
    rec_t        r;
    logic [31:0] s32;
    logic [31:0] p32;
    s32 = 32'(st);
    p32 = 32'(sp);
    if (st > OFF_LAST) begin
      s32 = 32'(OFF_LAST);
      p32 = 32'(OFF_LAST);
    end
    r.kind  = kind;
    r.start = s32[8:0];
    r.stop  = p32[9:0];
    r.index = ix;
    r.ovf   = ov;
    r.last  = lst;
    return r;
  endfunction

  assign acc = in_valid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    tbeg_nxt  = tbeg_r;
    lke_nxt   = lke_r;
    tseen_nxt = tseen_r;
    pm_nxt    = pm_r;
    ovf_nxt   = ovf_r;
    seg_go    = 1'b0;
    is_cmd    = 1'b0;
    is_pass   = 1'b0;
    idx       = '0;
    cnt       = '0;
    bnd       = '0;

    if (off_r < OFF_MAX) begin
      case (phase_r)
        PH_LINE_START, PH_TOK_START: begin
          if (in_line_byte == CH_COLON) begin
            phase_nxt = (phase_r == PH_LINE_START) ? PH_PREFIX : PH_REST;
            tbeg_nxt  = off_r + OFF_ONE;
          end else begin
            phase_nxt = PH_SEGMENT;
            lke_nxt   = '0;
            pm_nxt    = '0;
            seg_go    = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (in_line_byte == CH_SPACE) begin
            bnd.recs[cnt] = mk_rec(KIND_PREFIX, tbeg_nxt, off_r, 8'd0, ovf_nxt, 1'b0);
            cnt           = cnt + 2'd1;
            phase_nxt     = PH_TOK_START;
          end
        end
        PH_SEGMENT:    seg_go = 1'b1;
        PH_AFTER_PASS: begin
          phase_nxt = PH_REST;
          tbeg_nxt  = (in_line_byte == CH_COLON) ? off_r + OFF_ONE : off_r;
        end
        default: ;
      endcase

      if (seg_go) begin
        if (in_line_byte == CH_SPACE) begin
          is_cmd  = (tseen_nxt == 8'd0);
          is_pass = is_cmd && (lke_nxt != '0) && (pm_nxt == PM_MATCHED || pm_nxt == PM_HIT_WS);
          if (lke_nxt != '0) begin
            idx = tseen_nxt;
            if (tseen_nxt == 8'hFF) ovf_nxt = 1'b1;
            else tseen_nxt = tseen_nxt + 8'd1;
            bnd.recs[cnt] = mk_rec(is_cmd ? KIND_CMD : KIND_MIDDLE, tbeg_nxt, lke_nxt, idx,
                                   ovf_nxt, 1'b0);
            cnt = cnt + 2'd1;
          end
          phase_nxt = is_pass ? PH_AFTER_PASS : PH_TOK_START;
        end else if (is_ws(in_line_byte)) begin
          if (lke_nxt != '0) pm_nxt = pass_feed(pm_nxt, in_line_byte, 1'b1);
        end else begin
          if (lke_nxt == '0) tbeg_nxt = off_r;
          lke_nxt = off_r + OFF_ONE;
          pm_nxt  = pass_feed(pm_nxt, in_line_byte, 1'b0);
        end
      end
      off_nxt = off_r + OFF_ONE;
    end else begin
      ovf_nxt = 1'b1;
    end

    if (in_line_end) begin
      case (phase_nxt)
        PH_PREFIX: begin
          bnd.recs[cnt] = mk_rec(KIND_PREFIX, tbeg_nxt, off_nxt, 8'd0, ovf_nxt, 1'b0);
          cnt           = cnt + 2'd1;
        end
        PH_SEGMENT, PH_REST, PH_AFTER_PASS: begin
          if (phase_nxt != PH_SEGMENT || lke_nxt != '0) begin
            is_cmd = (tseen_nxt == 8'd0);
            idx    = tseen_nxt;
            if (tseen_nxt == 8'hFF) ovf_nxt = 1'b1;
            else tseen_nxt = tseen_nxt + 8'd1;
            case (phase_nxt)
              PH_SEGMENT: bnd.recs[cnt] = mk_rec(is_cmd ? KIND_CMD : KIND_MIDDLE, tbeg_nxt,
                                                 lke_nxt, idx, ovf_nxt, 1'b0);
              PH_REST:    bnd.recs[cnt] = mk_rec(KIND_REST, tbeg_nxt, off_nxt, idx,
                                                 ovf_nxt, 1'b0);
              default:    bnd.recs[cnt] = mk_rec(KIND_REST, off_nxt, off_nxt, idx,
                                                 ovf_nxt, 1'b0);
            endcase
            cnt = cnt + 2'd1;
          end
        end
        default: ;
      endcase
      bnd.recs[cnt] = mk_rec(KIND_END, '0, off_nxt, tseen_nxt, ovf_nxt, 1'b1);
      cnt           = cnt + 2'd1;
      // next line starts clean
      phase_nxt = PH_LINE_START;
      off_nxt   = '0;
      tbeg_nxt  = '0;
      lke_nxt   = '0;
      tseen_nxt = '0;
      pm_nxt    = '0;
      ovf_nxt   = 1'b0;
    end
    bnd.cnt = cnt;
  end

  assign push     = acc && (cnt != 2'd0);
  assign push_bnd = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE_START;
      off_r   <= '0;
      tbeg_r  <= '0;
      lke_r   <= '0;
      tseen_r <= '0;
      pm_r    <= '0;
      ovf_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      tbeg_r  <= tbeg_nxt;
      lke_r   <= lke_nxt;
      tseen_r <= tseen_nxt;
      pm_r    <= pm_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `ASSERT_CLK(a_line_restart, (acc && in_line_end) |=> (off_r == '0 && phase_r == PH_LINE_START && tseen_r == 8'd0), "state not cleared after line end")
  `ASSERT_CLK(a_off_bound, (off_r <= OFF_MAX) && ((off_r == OFF_MAX) || !(lke_r > off_r)), "offset tracking out of range")

endmodule

[src/irclt_queue.sv]
// Bundle queue between tokenizer front and back ends.
// Depends on irclt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module irclt_queue
  import irclt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_bnd,
  input  logic    pop,
  output logic    full,
  output logic    empty,
  output bundle_t head
);

  localparam int PTRW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  bundle_t         mem [QDEPTH];
  logic [PTRW-1:0] wptr_r, rptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CNTW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr_r] <= push_bnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PTRW'(QDEPTH - 1)) ? '0 : wptr_r + PTRW'(1);
      if (do_pop)  rptr_r <= (rptr_r == PTRW'(QDEPTH - 1)) ? '0 : rptr_r + PTRW'(1);
      if (do_push && !do_pop)      count_r <= count_r + CNTW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNTW'(1);
    end
  end

  `ASSERT_CLK(a_q_count, (do_push && !do_pop) |=> (count_r == $past(count_r) + CNTW'(1)), "queue count did not advance on push")

endmodule

[src/irclt_back.sv]
// Back end of the IRC line tokenizer: unpacks bundles into single records.
// Depends on irclt_pkg and assert_macros.svh; drains irclt_queue.
`include "assert_macros.svh"
module irclt_back
  import irclt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  bundle_t    head,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [2:0] out_token_kind,
  output logic [8:0] out_token_start,
  output logic [9:0] out_token_stop,
  output logic [7:0] out_token_index,
  output logic       out_overflow,
  output logic       out_last_of_line
);

  logic [1:0] sel_r;
  logic       valid_r;
  rec_t       rec_r;
  logic       load, at_last;

  assign load    = !q_empty && (!valid_r || !out_stall);
  assign at_last = (sel_r == head.cnt - 2'd1);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sel_r   <= at_last ? 2'd0 : sel_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) rec_r <= head.recs[sel_r];
  end

  assign out_valid        = valid_r;
  assign out_token_kind   = rec_r.kind;
  assign out_token_start  = rec_r.start;
  assign out_token_stop   = rec_r.stop;
  assign out_token_index  = rec_r.index;
  assign out_overflow     = rec_r.ovf;
  assign out_last_of_line = rec_r.last;

  `ASSERT_CLK(a_sel_in_bundle, !q_empty |-> (head.cnt != 2'd0 && sel_r < head.cnt), "record select outside bundle")
  `ASSERT_CLK(a_sel_idle, q_empty |-> (sel_r == 2'd0), "record select not at bundle start while queue empty")

endmodule

[src/irc_line_tokenizer.sv]
// Top level of the IRC line tokenizer.
// Depends on irclt_pkg, irclt_front, irclt_queue and irclt_back.
//
// Streaming tokenizer for IRC message lines. Bytes arrive one per transfer on
// the in_ channel, in_line_end marking the final byte of a line; for every
// token a descriptor record leaves on the out_ channel (kind, start and stop
// offsets, list index, overflow flag), and each line closes with an end record
// (kind 4, last_of_line set) that carries the kept byte count and token count.
// A leading ':' opens a prefix up to the first space; then the line splits on
// spaces with whitespace trimmed and empty pieces dropped; a piece starting
// with ':' takes the rest of the line; after a PASS command (any case) the rest
// of the line is one untrimmed parameter. Bytes at offset MAX_LINE and beyond
// are dropped and set overflow; the 256th token onward gets index 255.
// Rate: one byte is accepted every cycle while in_stall is low. The front end
// classifies the byte and updates the token state in that same cycle, packing
// the up to three records it causes into one bundle for a four-deep bundle
// queue (a byte with no record pushes nothing). The back end sends one record
// per cycle while out_stall is low, so a byte with several records holds the
// back end for each in turn; the queue absorbs those bursts and in_stall rises
// only when it is full. A record passes the bundle queue and the back end's
// output register to reach the out_ ports; it transfers when out_stall is low.
module irc_line_tokenizer
  import irclt_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_line_byte,
  input  logic       in_line_end,
  // token records
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [8:0] out_token_start,
  output logic [9:0] out_token_stop,
  output logic [7:0] out_token_index,
  output logic       out_overflow,
  output logic       out_last_of_line
);

  logic    q_full, q_empty, push, pop;
  bundle_t push_bnd, head;

  // backpressure only from a full queue
  assign in_stall = q_full;

  irclt_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_line_byte (in_line_byte),
    .in_line_end  (in_line_end),
    .q_full       (q_full),
    .push         (push),
    .push_bnd     (push_bnd)
  );

  irclt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_bnd (push_bnd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  irclt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_stop   (out_token_stop),
    .out_token_index  (out_token_index),
    .out_overflow     (out_overflow),
    .out_last_of_line (out_last_of_line)
  );

endmodule
